// ----- hdl/b85_pkg.sv -----
// shared types, constants and character tables for the base85 stream decoder
`timescale 1ns / 1ps

package b85_pkg;

	localparam int RADIX = 85;
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW = $clog2(JOBQ_DEPTH);
	localparam int JOBQ_CW = $clog2(JOBQ_DEPTH + 1);

	localparam logic [1:0] ALPHA_A85 = 2'd0;
	localparam logic [1:0] ALPHA_Z85 = 2'd1;
	localparam logic [1:0] ALPHA_RFC = 2'd2;

	localparam logic REG_ALPHABET = 1'b0;
	localparam logic REG_SKIP_WS = 1'b1;

	localparam logic [7:0] A85_FIRST = 8'd33;
	localparam logic [7:0] A85_LAST = 8'd117;

	localparam logic [8*RADIX-1:0] Z85_SET =
		"0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
	localparam logic [8*RADIX-1:0] RFC_SET = {
		"0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_",
		8'h60, "{|}~"};

	typedef enum logic [1:0] {
		KIND_SKIP   = 2'd0,
		KIND_FINISH = 2'd1,
		KIND_DIGIT  = 2'd2,
		KIND_BAD    = 2'd3
	} kind_t;

	typedef struct packed {
		logic ok;
		logic [6:0] val;
	} digit_t;

	// one group to emit: value, pad digits, index of its last byte
	typedef struct packed {
		logic err;
		logic [1:0] pad;
		logic [1:0] nlast;
		logic [31:0] value;
	} job_t;

	function automatic digit_t map_digit(input logic [1:0] sel, input logic [7:0] ch);
		digit_t r;
		logic [8*RADIX-1:0] set;
		r.ok = 1'b0;
		r.val = '0;
		case (sel)
			ALPHA_Z85: set = Z85_SET;
			ALPHA_RFC: set = RFC_SET;
			default: set = '0;
		endcase
		if (sel == ALPHA_Z85 || sel == ALPHA_RFC) begin
			for (int i = 0; i < RADIX; i++) begin
				if (set[8*(RADIX-1-i) +: 8] == ch) begin
					r.ok = 1'b1;
					r.val = 7'(i);
				end
			end
		end else if (ch >= A85_FIRST && ch <= A85_LAST) begin
			r.ok = 1'b1;
			r.val = 7'(ch - A85_FIRST);
		end
		return r;
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return ch == 8'd32 || ch == 8'd9 || ch == 8'd10 || ch == 8'd13 ||
			ch == 8'd12 || ch == 8'd11;
	endfunction

	// 85 to the power of the pad count
	function automatic logic [19:0] pow85(input logic [1:0] pad);
		logic [19:0] r;
		case (pad)
			2'd0: r = 20'd1;
			2'd1: r = 20'd85;
			2'd2: r = 20'd7225;
			2'd3: r = 20'd614125;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

	// value of pad digits 84 84 .. appended
	function automatic logic [19:0] pad85(input logic [1:0] pad);
		logic [19:0] r;
		case (pad)
			2'd0: r = 20'd0;
			2'd1: r = 20'd84;
			2'd2: r = 20'd7224;
			2'd3: r = 20'd614124;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/b85_front.sv -----
// front end: classifies characters and accumulates digit groups into jobs
`timescale 1ns / 1ps

module b85_front import b85_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  alphabet,
	input  logic        skip_ws,
	input  logic        push,
	output logic        full,
	input  logic        req_type,
	input  logic [7:0]  in_char,
	output logic        job_push,
	output job_t        job,
	input  logic        job_full
);

	logic valid_s1;
	kind_t kind_s1;
	logic [6:0] digit_s1;
	logic [2:0] cnt_q;
	logic [31:0] val_q;
	logic [2:0] cnt_d;
	logic [31:0] val_d;
	logic [31:0] next_val;
	logic stall;
	digit_t dmap;
	kind_t kind_in;

	always_comb begin
		dmap = map_digit(alphabet, in_char);
		if (req_type) begin
			kind_in = KIND_FINISH;
		end else if (skip_ws && is_space(in_char)) begin
			kind_in = KIND_SKIP;
		end else if (dmap.ok) begin
			kind_in = KIND_DIGIT;
		end else begin
			kind_in = KIND_BAD;
		end
	end

	assign stall = job_push && job_full;
	assign full = stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && push) begin
			kind_s1 <= kind_in;
			digit_s1 <= dmap.val;
		end
	end

	assign next_val = 32'(val_q * 32'd85) + {25'd0, digit_s1};

	always_comb begin
		job_push = 1'b0;
		job = '0;
		cnt_d = cnt_q;
		val_d = val_q;
		if (valid_s1) begin
			case (kind_s1)
				KIND_FINISH: begin
					if (cnt_q == 3'd1) begin
						job_push = 1'b1;
						job.err = 1'b1;
					end else if (cnt_q != 3'd0) begin
						job_push = 1'b1;
						job.pad = 2'(3'd5 - cnt_q);
						job.nlast = 2'(cnt_q - 3'd2);
						job.value = val_q;
					end
					cnt_d = 3'd0;
					val_d = '0;
				end
				KIND_DIGIT: begin
					if (cnt_q == 3'd4) begin
						job_push = 1'b1;
						job.nlast = 2'd3;
						job.value = next_val;
						cnt_d = 3'd0;
						val_d = '0;
					end else begin
						cnt_d = cnt_q + 3'd1;
						val_d = next_val;
					end
				end
				KIND_BAD: begin
					job_push = 1'b1;
					job.err = 1'b1;
					cnt_d = 3'd0;
					val_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			val_q <= '0;
		end else if (!stall) begin
			cnt_q <= cnt_d;
			val_q <= val_d;
		end
	end

	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !stall && kind_s1 == KIND_FINISH) |=> cnt_q == 3'd0)
		else $error("finish left digits pending");

	a_err_job_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(job_push && job.err) |-> (job.value == '0 && job.nlast == 2'd0))
		else $error("error job carries data");

endmodule

// ----- hdl/b85_job_fifo.sv -----
// short job queue between front end and back end
`timescale 1ns / 1ps

module b85_job_fifo import b85_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);

	job_t mem_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_ptr_q;
	logic [JOBQ_AW-1:0] rd_ptr_q;
	logic [JOBQ_CW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == JOBQ_CW'(JOBQ_DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + JOBQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + JOBQ_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + JOBQ_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - JOBQ_CW'(1);
			end
		end
	end

endmodule

// ----- hdl/b85_back.sv -----
// back end: pads groups by multiplication and serializes bytes to the result side
`timescale 1ns / 1ps

module b85_back import b85_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_job,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       error,
	output logic       last
);

	logic valid_s1;
	job_t job_s1;
	logic valid_s2;
	logic [3:0][7:0] word_s2;
	logic err_s2;
	logic [1:0] nlast_s2;
	logic [1:0] idx_s2;
	logic [51:0] prod;
	logic [31:0] word;
	logic out_done;
	logic s2_free;
	logic s1_free;

	assign prod = job_s1.value * pow85(job_s1.pad);
	assign word = prod[31:0] + {12'd0, pad85(job_s1.pad)};

	assign out_done = valid_s2 && pop && idx_s2 == nlast_s2;
	assign s2_free = !valid_s2 || out_done;
	assign s1_free = !valid_s1 || s2_free;
	assign q_pop = !q_empty && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_s2 <= 2'd0;
		end else begin
			if (s1_free) begin
				valid_s1 <= !q_empty;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
				idx_s2 <= 2'd0;
			end else if (pop) begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_s1 <= q_job;
		end
		if (s2_free && valid_s1) begin
			word_s2 <= word;
			err_s2 <= job_s1.err;
			nlast_s2 <= job_s1.nlast;
		end
	end

	assign empty = !valid_s2;
	assign out_byte = word_s2[2'd3 - idx_s2];
	assign error = err_s2;
	assign last = idx_s2 == nlast_s2;

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && err_s2) |-> (nlast_s2 == 2'd0 && word_s2 == '0))
		else $error("error beat not a single zero byte");

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && pop && idx_s2 != nlast_s2) |=>
		(valid_s2 && idx_s2 == $past(idx_s2) + 2'd1))
		else $error("byte index skipped");

endmodule

// ----- hdl/base85_stream_decoder.sv -----
// top level of the base85 stream decoder
`timescale 1ns / 1ps

// Input side is a queue: a character or finish beat is taken when push is
// high and full is low. Result side is a queue: while empty is low the
// oldest decoded byte is on out_byte/error/last and pop takes it.
// Configuration: wr_en writes wr_data into the register at wr_index
// (0 alphabet, 1 whitespace skip); write only while the decoder is idle.
// A group's first byte is shown once it has passed the classify stage, the
// job queue, the pad multiply stage and the result register.
// Throughput: one input beat per cycle while full is low; the byte
// serializer drains one result beat per cycle while pop is high. A
// four-entry job queue sits between the front end and the back end.
// When pop is held low the result register and then the job queue fill,
// and full rises once the front end has a job it cannot store.
// Reset clears the pending group, both queues and the registers
// (ASCII85, no whitespace skip).

module base85_stream_decoder import b85_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       req_type,
	input  logic [7:0] in_char,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       error,
	output logic       last,
	input  logic       wr_en,
	input  logic       wr_index,
	input  logic [1:0] wr_data
);

	logic [1:0] alphabet_q;
	logic skip_ws_q;
	logic job_push;
	job_t job;
	logic job_full;
	logic q_pop;
	job_t q_job;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_q <= ALPHA_A85;
			skip_ws_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_ALPHABET: alphabet_q <= wr_data;
				REG_SKIP_WS: skip_ws_q <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	b85_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.alphabet  (alphabet_q),
		.skip_ws   (skip_ws_q),
		.push      (push),
		.full      (full),
		.req_type  (req_type),
		.in_char   (in_char),
		.job_push  (job_push),
		.job       (job),
		.job_full  (job_full)
	);

	b85_job_fifo u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (job),
		.full     (job_full),
		.pop      (q_pop),
		.pop_job  (q_job),
		.empty    (q_empty)
	);

	b85_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_job    (q_job),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.error    (error),
		.last     (last)
	);

endmodule
